>>> src/ncds_pkg.sv
package ncds_pkg;
  localparam int TW = 48;
  localparam int DW = 24;

  localparam int DIES_PER_CHANNEL = 8;
  localparam int QUEUE_DEPTH = 256;

  localparam logic [1:0] K_READ  = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_ERASE = 2'd2;

  localparam logic [1:0] CH_IDLE = 2'd0;
  localparam logic [1:0] CH_CMD  = 2'd1;
  localparam logic [1:0] CH_DATA = 2'd2;

  localparam logic [2:0] D_IDLE       = 3'd0;
  localparam logic [2:0] D_CMD        = 3'd1;
  localparam logic [2:0] D_READ_WAIT  = 3'd2;
  localparam logic [2:0] D_READ_DATA  = 3'd3;
  localparam logic [2:0] D_WRITE_DATA = 3'd4;
  localparam logic [2:0] D_WRITE_WAIT = 3'd5;
  localparam logic [2:0] D_ERASE_WAIT = 3'd6;

  localparam logic [2:0] CFG_CMD   = 3'd0;
  localparam logic [2:0] CFG_XFER  = 3'd1;
  localparam logic [2:0] CFG_READ  = 3'd2;
  localparam logic [2:0] CFG_PROG  = 3'd3;
  localparam logic [2:0] CFG_ERASE = 3'd4;

  localparam logic [DW-1:0] RST_CMD   = 24'd1700;
  localparam logic [DW-1:0] RST_XFER  = 24'd1956;
  localparam logic [DW-1:0] RST_READ  = 24'd40000;
  localparam logic [DW-1:0] RST_PROG  = 24'd800000;
  localparam logic [DW-1:0] RST_ERASE = 24'd3000000;

  typedef struct packed {
    logic [8:0] tag;
    logic [2:0] die;
    logic [1:0] kind;
    logic       status;
  } done_t;

  function automatic logic [TW-1:0] later(input logic [TW-1:0] t, input logic [DW-1:0] d);
    logic [TW:0] s;
    s = {1'b0, t} + {{(TW+1-DW){1'b0}}, d};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction
endpackage

>>> src/ncds_queue_mem.sv
module ncds_queue_mem import ncds_pkg::*; #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [10:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [10:0]   rd_data
);
  logic [10:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> src/ncds_out_fifo.sv
module ncds_out_fifo import ncds_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  done_t push_data,
  input  logic  push_last,
  output logic  empty,
  output logic  valid,
  input  logic  ready,
  output done_t data,
  output logic  last
);
  localparam int AW = $clog2(DEPTH);
  done_t      mem_d [0:DEPTH-1];
  logic       mem_l [0:DEPTH-1];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic pop;
  assign valid = cnt_r != '0;
  assign empty = !valid;
  assign pop = valid && ready;
  assign data = mem_d[rp_r];
  assign last = mem_l[rp_r];
  always_ff @(posedge clk) begin
    if (push) begin
      mem_d[wp_r] <= push_data;
      mem_l[wp_r] <= push_last;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

>>> src/nand_channel_die_scheduler.sv
// The block takes a new item only in its idle state: on a channel in a command or data
// phase it steps through the emit and wrap-up states; on an idle channel it runs an 8-die
// retire scan, up to two 8-die pick scans (queued commands, then read-ready dies), a queue
// memory read where a queued command is picked, and wrap-up.
// Results drain through a 16-entry output FIFO; the next item waits for it to empty.
// Reset: synchronous active-low; clears control state and loads default durations.
module nand_channel_die_scheduler import ncds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now[47:0], cmd_valid[48], target_die[51:49], cmd_tag[60:52], cmd_kind[62:61]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // done_tag[8:0], done_die[11:9], done_kind[13:12], done_status[14]
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int ND = DIES_PER_CHANNEL;
  localparam int DB = (ND > 1) ? $clog2(ND) : 1;
  localparam int QB = $clog2(QUEUE_DEPTH);
  localparam int CB = QB + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_RET = 3'd1, S_PICK = 3'd2,
    S_RD = 3'd3, S_USE = 3'd4, S_EMIT = 3'd5, S_WAIT = 3'd6;

  logic [DW-1:0] dur_cmd_r, dur_xfer_r, dur_read_r, dur_prog_r, dur_erase_r;
  logic [2:0] st_r;
  logic [TW-1:0] now_r;
  logic [1:0] ch_phase_r, ch_kind_r;
  logic [TW-1:0] ch_dl_r;
  logic [8:0] ch_tag_r;
  logic [DB-1:0] ch_die_r, rr_r, scan_r, pick_r;
  logic [2:0] d_phase_r [0:ND-1];
  logic [TW-1:0] d_dl_r [0:ND-1];
  logic [8:0] d_tag_r [0:ND-1];
  logic [1:0] d_kind_r [0:ND-1];
  logic [ND-1:0] d_av_r;
  logic [QB-1:0] q_head_r [0:ND-1];
  logic [QB-1:0] q_tail_r [0:ND-1];
  logic [CB-1:0] q_cnt_r [0:ND-1];

  // pending result before push, a copy of the held result; at most one pushed per cycle
  done_t pend_r;
  logic pend_v_r;

  logic push, push_last, fifo_empty;
  done_t push_d, fdata;
  logic wr_en;
  logic [DB+QB-1:0] wr_addr, rd_addr;
  logic [10:0] wr_data, rd_data;

  logic [2:0] in_die3;
  logic [1:0] in_kind;
  logic in_acc;
  logic [TW-1:0] in_now;

  assign in_now = in_tdata[47:0];
  assign in_die3 = in_tdata[51:49];
  assign in_kind = (in_tdata[62:61] == 2'd3) ? K_ERASE : in_tdata[62:61];
  assign in_tready = (st_r == S_IDLE) && fifo_empty;
  assign in_acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // result push happens on a delayed slot; "last" resolved by holding one result
  done_t hold_r;
  logic hold_v_r;
  logic res_v;
  done_t res_d;
  logic fin;

  ncds_queue_mem #(.AW(DB+QB)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  ncds_out_fifo #(.DEPTH(16)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_d), .push_last(push_last),
    .empty(fifo_empty), .valid(out_tvalid), .ready(out_tready), .data(fdata),
    .last(out_tlast)
  );
  assign out_tdata = {1'b0, fdata.status, fdata.kind, fdata.die, fdata.tag};

  logic in_ok;
  assign in_ok = (32'(in_die3) < ND) &&
    (q_cnt_r[in_die3[DB-1:0]] < CB'(QUEUE_DEPTH));
  assign wr_en = in_acc && in_tdata[48] && in_ok;
  assign wr_addr = {in_die3[DB-1:0], q_head_r[in_die3[DB-1:0]]};
  assign wr_data = {in_kind, in_tdata[60:52]};
  assign rd_addr = {pick_r, q_tail_r[pick_r]};

  // result from the current cycle's step
  logic ret_hit, rd_hit, q_hit;
  assign ret_hit = (d_phase_r[scan_r] == D_WRITE_WAIT || d_phase_r[scan_r] == D_ERASE_WAIT)
    && d_av_r[scan_r] && now_r >= d_dl_r[scan_r];
  assign q_hit = d_phase_r[scan_r] == D_IDLE && q_cnt_r[scan_r] != '0;
  assign rd_hit = d_phase_r[scan_r] == D_READ_WAIT && now_r >= d_dl_r[scan_r];

  logic [DB:0] cnt_r;
  logic pass2_r;
  logic [DB-1:0] scan_inc;
  assign scan_inc = (32'(scan_r) == ND-1) ? '0 : scan_r + 1'b1;

  always_comb begin
    res_v = 1'b0;
    res_d = '0;
    fin = 1'b0;
    if (st_r == S_IDLE && in_acc && in_tdata[48] && !in_ok) begin
      res_v = 1'b1;
      res_d = '{tag: in_tdata[60:52], die: in_die3, kind: in_kind, status: 1'b1};
    end
    if (st_r == S_RET && ret_hit) begin
      res_v = 1'b1;
      res_d = '{tag: d_tag_r[scan_r], die: 3'(scan_r), kind: d_kind_r[scan_r],
                status: 1'b0};
    end
    if (st_r == S_EMIT && ch_phase_r == CH_DATA && now_r >= ch_dl_r &&
        ch_kind_r == K_READ) begin
      res_v = 1'b1;
      res_d = '{tag: ch_tag_r, die: 3'(ch_die_r), kind: K_READ, status: 1'b0};
    end
    fin = (st_r == S_WAIT);
  end

  assign push = (res_v && hold_v_r) || (fin && hold_v_r);
  assign push_d = hold_r;
  assign push_last = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_cmd_r <= RST_CMD;
      dur_xfer_r <= RST_XFER;
      dur_read_r <= RST_READ;
      dur_prog_r <= RST_PROG;
      dur_erase_r <= RST_ERASE;
      st_r <= S_IDLE;
      ch_phase_r <= CH_IDLE;
      ch_kind_r <= K_READ;
      ch_dl_r <= '0;
      ch_tag_r <= '0;
      ch_die_r <= '0;
      rr_r <= '0;
      scan_r <= '0;
      pick_r <= '0;
      cnt_r <= '0;
      pass2_r <= 1'b0;
      hold_v_r <= 1'b0;
      d_av_r <= '0;
      for (int i = 0; i < ND; i++) begin
        d_phase_r[i] <= D_IDLE;
        d_dl_r[i] <= '0;
        d_tag_r[i] <= '0;
        d_kind_r[i] <= '0;
        q_head_r[i] <= '0;
        q_tail_r[i] <= '0;
        q_cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CMD:   dur_cmd_r <= cfg_data;
          CFG_XFER:  dur_xfer_r <= cfg_data;
          CFG_READ:  dur_read_r <= cfg_data;
          CFG_PROG:  dur_prog_r <= cfg_data;
          CFG_ERASE: dur_erase_r <= cfg_data;
          default: ;
        endcase
      end
      if (res_v) begin
        hold_r <= res_d;
        hold_v_r <= 1'b1;
      end else if (fin) begin
        hold_v_r <= 1'b0;
      end
      if (wr_en) begin
        q_head_r[in_die3[DB-1:0]] <= q_head_r[in_die3[DB-1:0]] + 1'b1;
        q_cnt_r[in_die3[DB-1:0]] <= q_cnt_r[in_die3[DB-1:0]] + 1'b1;
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r <= in_now;
            scan_r <= '0;
            if (ch_phase_r == CH_CMD || ch_phase_r == CH_DATA) begin
              st_r <= S_EMIT;
            end else begin
              st_r <= S_RET;
            end
          end
        end
        S_RET: begin
          if (ret_hit) begin
            d_av_r[scan_r] <= 1'b0;
            d_phase_r[scan_r] <= D_IDLE;
          end
          if (32'(scan_r) == ND-1) begin
            st_r <= S_PICK;
            scan_r <= rr_r;
            cnt_r <= '0;
            pass2_r <= 1'b0;
            ch_phase_r <= CH_IDLE;
          end else begin
            scan_r <= scan_inc;
          end
        end
        S_PICK: begin
          if (!pass2_r && q_hit) begin
            pick_r <= scan_r;
            st_r <= S_RD;
          end else if (pass2_r && rd_hit) begin
            ch_phase_r <= CH_DATA;
            ch_dl_r <= later(now_r, dur_xfer_r);
            ch_tag_r <= d_tag_r[scan_r];
            ch_kind_r <= K_READ;
            ch_die_r <= scan_r;
            d_phase_r[scan_r] <= D_READ_DATA;
            rr_r <= scan_inc;
            st_r <= S_WAIT;
          end else begin
            scan_r <= scan_inc;
            if (32'(cnt_r) == ND-1) begin
              cnt_r <= '0;
              if (pass2_r) st_r <= S_WAIT;
              pass2_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_RD: st_r <= S_USE;
        S_USE: begin
          q_tail_r[pick_r] <= q_tail_r[pick_r] + 1'b1;
          q_cnt_r[pick_r] <= q_cnt_r[pick_r] - 1'b1;
          d_tag_r[pick_r] <= rd_data[8:0];
          d_kind_r[pick_r] <= rd_data[10:9];
          d_av_r[pick_r] <= 1'b1;
          d_phase_r[pick_r] <= D_CMD;
          ch_phase_r <= CH_CMD;
          ch_dl_r <= later(now_r, dur_cmd_r);
          ch_tag_r <= rd_data[8:0];
          ch_kind_r <= rd_data[10:9];
          ch_die_r <= pick_r;
          rr_r <= (32'(pick_r) == ND-1) ? '0 : pick_r + 1'b1;
          st_r <= S_WAIT;
        end
        S_EMIT: begin
          st_r <= S_WAIT;
          if (now_r >= ch_dl_r) begin
            if (ch_phase_r == CH_CMD) begin
              if (ch_kind_r == K_READ) begin
                d_phase_r[ch_die_r] <= D_READ_WAIT;
                d_dl_r[ch_die_r] <= later(now_r, dur_read_r);
              end else if (ch_kind_r == K_WRITE) begin
                d_phase_r[ch_die_r] <= D_WRITE_DATA;
                ch_dl_r <= later(now_r, dur_xfer_r);
              end else begin
                d_phase_r[ch_die_r] <= D_ERASE_WAIT;
                d_dl_r[ch_die_r] <= later(now_r, dur_erase_r);
              end
            end else begin
              if (ch_kind_r == K_READ) begin
                d_av_r[ch_die_r] <= 1'b0;
                d_phase_r[ch_die_r] <= D_IDLE;
              end else if (ch_kind_r == K_WRITE) begin
                d_phase_r[ch_die_r] <= D_WRITE_WAIT;
                d_dl_r[ch_die_r] <= later(now_r, dur_prog_r);
              end
            end
            if (ch_phase_r == CH_CMD && ch_kind_r == K_WRITE) begin
              ch_phase_r <= CH_DATA;
            end else begin
              ch_phase_r <= CH_IDLE;
              ch_tag_r <= '0;
              ch_kind_r <= K_READ;
              ch_die_r <= '0;
            end
          end
        end
        S_WAIT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign pend_r = hold_r;
  assign pend_v_r = hold_v_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_last_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_last) |=> !hold_v_r) else $error("hold not cleared");
  a_use_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_USE |-> $past(st_r) == S_RD) else $error("bad read sequence");
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && st_r == S_IDLE) |-> pend_r == hold_r) else $error("pend mismatch");
endmodule

>>> tb/sv/tb.sv
module tb;
  import ncds_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    done_t d;
    logic  last;
  } sched_result_t;

  typedef struct {
    logic [47:0] now;
    bit          cv;
    logic [2:0]  die;
    logic [8:0]  tag;
    logic [1:0]  kind;
    bit          quiet;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_CMD;
  logic [23:0] cfg_data = '0;

  nand_channel_die_scheduler uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sched_result_t pending_done[$];
  int errors = 0;
  int dir_errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;
  logic [47:0] t_now = '0;

  // scheduler state
  logic [23:0] dur [5];
  logic [1:0]  ch_phase;
  logic [47:0] ch_deadline;
  logic [8:0]  ch_tag;
  logic [1:0]  ch_kind;
  logic [2:0]  ch_die;
  logic [2:0]  rr_next;
  logic [2:0]  die_st [8];
  logic [47:0] die_dl [8];
  logic [8:0]  die_tag [8];
  logic [1:0]  die_kind [8];
  logic        die_busy [8];
  logic [10:0] qmem [8][256];
  logic [7:0]  q_head [8];
  logic [7:0]  q_tail [8];
  int          q_cnt [8];

  function automatic logic [47:0] sat_add(logic [47:0] t, logic [23:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {25'd0, d};
    return s[48] ? TMAX : s[47:0];
  endfunction

  task automatic sched_reset();
    dur[CFG_CMD] = RST_CMD;
    dur[CFG_XFER] = RST_XFER;
    dur[CFG_READ] = RST_READ;
    dur[CFG_PROG] = RST_PROG;
    dur[CFG_ERASE] = RST_ERASE;
    ch_phase = CH_IDLE; ch_deadline = '0; ch_tag = '0; ch_kind = K_READ; ch_die = '0;
    rr_next = '0;
    for (int i = 0; i < 8; i++) begin
      die_st[i] = D_IDLE; die_dl[i] = '0; die_tag[i] = '0; die_kind[i] = K_READ;
      die_busy[i] = 0; q_head[i] = '0; q_tail[i] = '0; q_cnt[i] = 0;
    end
  endtask

  task automatic channel_idle();
    ch_phase = CH_IDLE; ch_tag = '0; ch_kind = K_READ; ch_die = '0;
  endtask

  task automatic schedule_step(input logic [47:0] now, input bit cv, input logic [2:0] die,
                               input logic [8:0] tag, input logic [1:0] kin, input bit quiet);
    done_t r[$];
    logic [1:0] k;
    int d;
    bit picked;
    logic [10:0] e;
    picked = 0;
    if (cv) begin
      k = (kin == 2'd3) ? K_ERASE : kin;
      if (q_cnt[die] >= 256) r.push_back({tag, die, k, 1'b1});
      else begin
        qmem[die][q_head[die]] = {k, tag};
        q_head[die]++;
        q_cnt[die]++;
      end
    end
    if (ch_phase == CH_CMD) begin
      if (now >= ch_deadline) begin
        d = ch_die;
        if (ch_kind == K_READ) begin
          die_st[d] = D_READ_WAIT; die_dl[d] = sat_add(now, dur[CFG_READ]); channel_idle();
        end else if (ch_kind == K_WRITE) begin
          die_st[d] = D_WRITE_DATA; ch_phase = CH_DATA;
          ch_deadline = sat_add(now, dur[CFG_XFER]);
        end else begin
          die_st[d] = D_ERASE_WAIT; die_dl[d] = sat_add(now, dur[CFG_ERASE]); channel_idle();
        end
      end
    end else if (ch_phase == CH_DATA) begin
      if (now >= ch_deadline) begin
        d = ch_die;
        if (ch_kind == K_READ) begin
          r.push_back({ch_tag, ch_die, K_READ, 1'b0});
          die_busy[d] = 0; die_st[d] = D_IDLE;
        end else if (ch_kind == K_WRITE) begin
          die_st[d] = D_WRITE_WAIT; die_dl[d] = sat_add(now, dur[CFG_PROG]);
        end
        channel_idle();
      end
    end else begin
      ch_phase = CH_IDLE;
      for (int j = 0; j < 8; j++)
        if ((die_st[j] == D_WRITE_WAIT || die_st[j] == D_ERASE_WAIT) && die_busy[j] &&
            now >= die_dl[j]) begin
          r.push_back({die_tag[j], 3'(j), die_kind[j], 1'b0});
          die_busy[j] = 0; die_st[j] = D_IDLE;
        end
      for (int j = 0; j < 8 && !picked; j++) begin
        d = (rr_next + j) % 8;
        if (die_st[d] == D_IDLE && q_cnt[d] != 0) begin
          e = qmem[d][q_tail[d]];
          q_tail[d]++; q_cnt[d]--;
          die_tag[d] = e[8:0]; die_kind[d] = e[10:9]; die_busy[d] = 1; die_st[d] = D_CMD;
          ch_phase = CH_CMD; ch_deadline = sat_add(now, dur[CFG_CMD]);
          ch_tag = e[8:0]; ch_kind = e[10:9]; ch_die = 3'(d);
          rr_next = 3'((d + 1) % 8); picked = 1;
        end
      end
      for (int j = 0; j < 8 && !picked; j++) begin
        d = (rr_next + j) % 8;
        if (die_st[d] == D_READ_WAIT && now >= die_dl[d]) begin
          ch_phase = CH_DATA; ch_deadline = sat_add(now, dur[CFG_XFER]);
          ch_tag = die_tag[d]; ch_kind = K_READ; ch_die = 3'(d);
          die_st[d] = D_READ_DATA; rr_next = 3'((d + 1) % 8); picked = 1;
        end
      end
    end
    if (quiet) begin
      if (r.size() != 0) begin
        $error("directed row: expected no result, model gives %0d", r.size());
        dir_errors++;
      end
    end else
      foreach (r[i]) pending_done.push_back('{d: r[i], last: (i == r.size() - 1)});
  endtask

  task automatic send_item(input stim_row_t s);
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 0;
        @(posedge clk);
      end
    in_tvalid <= 1;
    in_tdata <= {1'b0, s.kind, s.tag, s.die, s.cv, s.now};
    do @(posedge clk); while (!in_tready);
    schedule_step(s.now, s.cv, s.die, s.tag, s.kind, s.quiet);
  endtask

  task automatic send_random(input int span, input int burst_die);
    stim_row_t s;
    t_now = t_now + $urandom_range(span);
    s.now = t_now;
    s.cv = (burst_die >= 0) || ($urandom_range(99) < 70);
    s.die = (burst_die >= 0) ? 3'(burst_die) : 3'($urandom_range(7));
    s.tag = 9'($urandom_range(511));
    s.kind = 2'($urandom_range(3));
    s.quiet = 0;
    send_item(s);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_done.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_durations(input logic [23:0] v[5]);
    logic [2:0] idx [5];
    idx = '{CFG_CMD, CFG_XFER, CFG_READ, CFG_PROG, CFG_ERASE};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1;
      cfg_index <= idx[i];
      cfg_data <= v[i];
      do @(posedge clk); while (!cfg_ready);
      dur[idx[i]] = v[i];
    end
    cfg_valid <= 0;
  endtask

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
    end else
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_done.size() == 0) begin
        $error("result transfer with nothing pending: %h", out_tdata);
        errors++;
      end else begin
        sched_result_t x;
        x = pending_done.pop_front();
        if (out_tdata[8:0] !== x.d.tag) begin
          $error("done_tag expected %0d actual %0d", x.d.tag, out_tdata[8:0]); errors++;
        end
        if (out_tdata[11:9] !== x.d.die) begin
          $error("done_die expected %0d actual %0d", x.d.die, out_tdata[11:9]); errors++;
        end
        if (out_tdata[13:12] !== x.d.kind) begin
          $error("done_kind expected %0d actual %0d", x.d.kind, out_tdata[13:12]); errors++;
        end
        if (out_tdata[14] !== x.d.status) begin
          $error("done_status expected %0d actual %0d", x.d.status, out_tdata[14]); errors++;
        end
        if (out_tlast !== x.last) begin
          $error("last expected %0d actual %0d", x.last, out_tlast); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  stim_row_t directed [18] = '{
    '{48'd0,       1, 3'd0, 9'd1,   K_WRITE, 1},
    '{48'd100,     1, 3'd7, 9'd511, K_READ,  1},
    '{48'd1700,    1, 3'd2, 9'h155, 2'd3,    1},
    '{48'd3656,    0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd3657,    1, 3'd5, 9'h0AA, K_ERASE, 0},
    '{48'd5400,    0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd5401,    0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd7200,    1, 3'd7, 9'd300, K_READ,  0},
    '{48'd9000,    0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd60000,   0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd62000,   0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd64000,   1, 3'd1, 9'd0,   K_WRITE, 0},
    '{48'd70000,   0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd72000,   0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd900000,  0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd4000000, 0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd4100000, 0, 3'd0, 9'd0,   K_READ,  0},
    '{48'd4200000, 1, 3'd6, 9'd256, 2'd3,    0}
  };

  initial begin
    logic [23:0] v [5];
    int span;
    sched_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i]);
    t_now = directed[17].now;
    drain();
    for (int p = 0; p < 5; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (p)
        0: span = 300000;
        1: begin v = '{0, 0, 0, 0, 0}; span = 50; end
        2: begin
          foreach (v[i]) v[i] = 24'($urandom_range(3000));
          span = 2000;
        end
        3: begin
          foreach (v[i]) v[i] = 24'($urandom_range(200000));
          span = 60000;
        end
        default: begin
          v = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
          span = 4000000;
          t_now = TMAX - 48'd200000000;
        end
      endcase
      if (p > 0) write_durations(v);
      if (p == 1) hold_req = 1;
      if (p == 0) begin
        for (int i = 0; i < 20; i++) send_random(span, -1);
        for (int i = 0; i < 265; i++) send_random(5, 3);
      end
      for (int i = 0; i < 28; i++) send_random(span, -1);
      if (p == 4) begin
        t_now = TMAX;
        for (int i = 0; i < 10; i++) send_random(0, -1);
      end
      drain();
    end
    if (errors == 0 && dir_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

>>> sim.f
src/ncds_pkg.sv
src/ncds_queue_mem.sv
src/ncds_out_fifo.sv
src/nand_channel_die_scheduler.sv
tb/sv/tb.sv
